### design/fixed_point_biquad_lowpass_unit_macros.svh
// assertion helpers shared by the filter rtl
`ifndef FIXED_POINT_BIQUAD_LOWPASS_UNIT_MACROS_SVH
`define FIXED_POINT_BIQUAD_LOWPASS_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FPBQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FPBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fpbq_pkg.sv
package fpbq_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int SAT_BITS  = 28;
    localparam int OUT_SHIFT = 4;
    localparam int CFG_IDX_W = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    localparam cfg_idx_t REG_COEF_B0 = cfg_idx_t'(0);
    localparam cfg_idx_t REG_COEF_B1 = cfg_idx_t'(1);
    localparam cfg_idx_t REG_COEF_A1 = cfg_idx_t'(2);
    localparam cfg_idx_t REG_COEF_A2 = cfg_idx_t'(3);

    localparam logic signed [SAT_BITS-1:0] SAT_MAX = {1'b0, {(SAT_BITS-1){1'b1}}};
    localparam logic signed [SAT_BITS-1:0] SAT_MIN = {1'b1, {(SAT_BITS-1){1'b0}}};

endpackage

### design/fixed_point_biquad_lowpass_unit.sv
// Second-order low-pass section, direct form I, fixed point.
// Input request: s_valid / s_ready with s_sample_in (signed 32 bits).
// Result request: m_valid / m_ready with m_sample_out (signed 32 bits,
// a 28-bit saturated value shifted left 4, low four bits zero).
// Coefficients b0, b1, a1, a2 are written through cfg_wr_en / cfg_index /
// cfg_data at indexes 0..3; other indexes are ignored. Write only while idle.
// A request accepted into the input register moves to the result register, and
// so onto m_*, when that register is free. Throughput is one sample per cycle
// while no result is held or m_ready is high: the five 32x32 products, their
// sum and saturation sit in one stage between the input register and the
// result register, and the past output is loaded on the same edge as the result.
// Reset (aresetn low, synchronous) clears coefficients, the filter history
// and both valid flags.
// When the receiver stalls, the result register holds and one further
// request can sit in the input register; s_ready drops only when both are
// full and m_ready is low.
module fixed_point_biquad_lowpass_unit
    import fpbq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sample_t  s_sample_in,
    output logic     m_valid,
    input  logic     m_ready,
    output sample_t  m_sample_out,
    input  logic     cfg_wr_en,
    input  cfg_idx_t cfg_index,
    input  sample_t  cfg_data
);

    sample_t coef_b0_reg, coef_b1_reg, coef_a1_reg, coef_a2_reg;
    sample_t past_in_1_reg, past_in_2_reg, past_out_1_reg, past_out_2_reg;
    sample_t x_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    sample_t out_reg;

    logic    out_free;
    logic    advance;
    prod_t   p_b0x, p_b0x2, p_b1x1, p_a1y1, p_a2y2;
    sample_t acc;
    logic signed [SAT_BITS-1:0] sat;
    sample_t out_next;
    logic    in_valid_next;
    logic    out_valid_next;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_comb begin
        p_b0x  = prod_t'(coef_b0_reg) * prod_t'(x_reg);
        p_b0x2 = prod_t'(coef_b0_reg) * prod_t'(past_in_2_reg);
        p_b1x1 = prod_t'(coef_b1_reg) * prod_t'(past_in_1_reg);
        p_a1y1 = prod_t'(coef_a1_reg) * prod_t'(past_out_1_reg);
        p_a2y2 = prod_t'(coef_a2_reg) * prod_t'(past_out_2_reg);
        // high halves summed with 32-bit wrap
        acc = p_b0x[PROD_W-1:SAMPLE_W] + p_b0x2[PROD_W-1:SAMPLE_W]
            + p_b1x1[PROD_W-1:SAMPLE_W] + p_a1y1[PROD_W-1:SAMPLE_W]
            + p_a2y2[PROD_W-1:SAMPLE_W];
        // in range when the sign of the 28-bit field and all bits above it agree
        if ((&acc[SAMPLE_W-1:SAT_BITS-1]) || !(|acc[SAMPLE_W-1:SAT_BITS-1])) begin
            sat = acc[SAT_BITS-1:0];
        end else if (acc[SAMPLE_W-1]) begin
            sat = SAT_MIN;
        end else begin
            sat = SAT_MAX;
        end
        out_next = {sat, {OUT_SHIFT{1'b0}}};
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            coef_b0_reg    <= '0;
            coef_b1_reg    <= '0;
            coef_a1_reg    <= '0;
            coef_a2_reg    <= '0;
            past_in_1_reg  <= '0;
            past_in_2_reg  <= '0;
            past_out_1_reg <= '0;
            past_out_2_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_COEF_B0: coef_b0_reg <= cfg_data;
                    REG_COEF_B1: coef_b1_reg <= cfg_data;
                    REG_COEF_A1: coef_a1_reg <= cfg_data;
                    REG_COEF_A2: coef_a2_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (advance) begin
                past_in_2_reg  <= past_in_1_reg;
                past_in_1_reg  <= x_reg;
                past_out_2_reg <= past_out_1_reg;
                past_out_1_reg <= out_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_sample_in;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_reg;

`include "fixed_point_biquad_lowpass_unit_macros.svh"

    `FPBQ_ASSERT_NOW(a_out_is_history, out_valid_reg, out_reg == past_out_1_reg,
        "presented result differs from first past output")
    `FPBQ_ASSERT_NEXT(a_history_shift, advance,
        past_in_1_reg == $past(x_reg) && past_out_2_reg == $past(past_out_1_reg),
        "filter history did not shift on advance")
    `FPBQ_ASSERT_NOW(a_ready_low_only_full, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready,
        "input stalled while a stage was free")
    `FPBQ_ASSERT_NOW(a_low_bits_zero, out_valid_reg, out_reg[OUT_SHIFT-1:0] == '0,
        "result low bits not zero")

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fpbq_pkg::*;

    // indexes with no register behind them
    localparam cfg_idx_t NO_REG_FIRST = cfg_idx_t'(4);
    localparam cfg_idx_t NO_REG_LAST  = '1;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 100;

    logic     aclk        = 1'b0;
    logic     aresetn     = 1'b0;
    logic     s_valid     = 1'b0;
    logic     s_ready;
    sample_t  s_sample_in = '0;
    logic     m_valid;
    logic     m_ready     = 1'b0;
    sample_t  m_sample_out;
    logic     cfg_wr_en   = 1'b0;
    cfg_idx_t cfg_index   = '0;
    sample_t  cfg_data    = '0;

    // filter coefficients and history as the block should hold them
    sample_t coef_b0 = '0;
    sample_t coef_b1 = '0;
    sample_t coef_a1 = '0;
    sample_t coef_a2 = '0;
    sample_t hist_x1 = '0;
    sample_t hist_x2 = '0;
    sample_t hist_y1 = '0;
    sample_t hist_y2 = '0;

    sample_t pending_in[$];
    sample_t expected_out[$];

    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    int  mismatch_count = 0;
    bit  in_fire        = 1'b0;

    fixed_point_biquad_lowpass_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // high half of the signed 32x32 product
    function automatic sample_t mul_high(sample_t a, sample_t b);
        prod_t p;
        p = prod_t'(a) * prod_t'(b);
        return p[PROD_W-1:SAMPLE_W];
    endfunction

    function automatic sample_t filter_step(sample_t x);
        sample_t                     acc;
        logic signed [SAT_BITS-1:0]  sat;
        sample_t                     y;
        // five terms, 32-bit wrap
        acc = mul_high(coef_b0, x) + mul_high(coef_b0, hist_x2) + mul_high(coef_b1, hist_x1)
            + mul_high(coef_a1, hist_y1) + mul_high(coef_a2, hist_y2);
        if (acc > sample_t'(SAT_MAX)) begin
            sat = SAT_MAX;
        end else if (acc < sample_t'(SAT_MIN)) begin
            sat = SAT_MIN;
        end else begin
            sat = acc[SAT_BITS-1:0];
        end
        y = sample_t'(sat) <<< OUT_SHIFT;
        hist_x2 = hist_x1;
        hist_x1 = x;
        hist_y2 = hist_y1;
        hist_y1 = y;
        return y;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $signed($urandom) >>> $urandom_range(4, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic sample_t random_coef();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_coef(cfg_idx_t idx, sample_t val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COEF_B0: coef_b0 = val;
            REG_COEF_B1: coef_b1 = val;
            REG_COEF_A1: coef_a1 = val;
            REG_COEF_A2: coef_a2 = val;
            default: ;
        endcase
    endtask

    task automatic set_coefs(sample_t b0, sample_t b1, sample_t a1, sample_t a2);
        write_coef(REG_COEF_B0, b0);
        write_coef(REG_COEF_B1, b1);
        write_coef(REG_COEF_A1, a1);
        write_coef(REG_COEF_A2, a2);
    endtask

    // sender holds off until every result is back
    task automatic wait_drained();
        while (pending_in.size() != 0 || s_valid || expected_out.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_random(int n);
        repeat (n) pending_in.push_back(random_sample());
        wait_drained();
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_in.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid     <= 1'b1;
                s_sample_in <= pending_in.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        sample_t want;
        in_fire = aresetn && s_valid && s_ready;
        if (in_fire)
            expected_out.push_back(filter_step(s_sample_in));
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: sample_out %h", m_sample_out);
            end else begin
                want = expected_out.pop_front();
                if (m_sample_out !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("sample_out mismatch: expected %h actual %h",
                                 want, m_sample_out);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL fixed_point_biquad_lowpass_unit");
        $finish;
    end

    initial begin
        sample_t b0;
        send_idle_pct = 18;
        recv_idle_pct = 61;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero coefficients after reset, then writes to unused indexes
        pending_in.push_back(32'h7FFF_FFFF);
        pending_in.push_back(32'h8000_0000);
        wait_drained();
        write_coef(NO_REG_FIRST, 32'h1234_5678);
        write_coef(NO_REG_LAST, 32'h7FFF_FFFF);
        pending_in.push_back(32'h7FFF_FFFF);
        wait_drained();

        // saturation at both ends
        set_coefs(32'h7FFF_FFFF, 32'h3FFF_FFFF, '0, '0);
        pending_in.push_back(32'h7FFF_FFFF);
        pending_in.push_back(32'h8000_0000);
        pending_in.push_back('0);
        pending_in.push_back('1);
        pending_in.push_back(32'h0000_0001);
        pending_in.push_back(32'h0000_1000);
        wait_drained();

        // most negative everywhere: the sum wraps before saturation
        set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        repeat (3) pending_in.push_back(32'h8000_0000);
        repeat (2) pending_in.push_back(32'h7FFF_FFFF);
        wait_drained();

        // strong feedback, unstable on purpose
        set_coefs(32'h0400_0000, 32'h0200_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        pending_in.push_back(32'h4000_0000);
        repeat (4) pending_in.push_back('0);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 18;
                recv_idle_pct = 61;
            end else if (p < 6) begin
                send_idle_pct = 61;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p % 2 == 0) begin
                // low-pass-like shape with b1 = b0 / 2
                b0 = $urandom_range(0, 32'h0FFF_FFFF);
                set_coefs(b0, b0 >>> 1, $urandom_range(0, 32'h7FFF_FFFF),
                          -sample_t'($urandom_range(0, 32'h3FFF_FFFF)));
            end else begin
                set_coefs(random_coef(), random_coef(), random_coef(), random_coef());
            end
            send_random(ITEMS_PER_PHASE / 2);
            send_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_out.size() == 0) begin
            $display("PASS fixed_point_biquad_lowpass_unit");
        end else begin
            $display("FAIL fixed_point_biquad_lowpass_unit");
        end
        $finish;
    end

endmodule
